### src/fmw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmw_pkg
// Shared constants and types for the frame FIFO with watermark flags.
// ----------------------------------------------------------------------------
package fmw_pkg;

    // Fixed bus widths of the word fields
    localparam int FRAME_BUS_W = 64;
    localparam int OCC_W       = 5;
    localparam int LVL_W       = 5;
    localparam int TOTAL_W     = 32;
    localparam int CFG_IDX_W   = 1;

    // Defaults for the top-level parameters
    localparam int DEF_DEPTH       = 16;
    localparam int DEF_FRAME_WIDTH = 64;

    // Operation codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WARN_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_LEVEL = 1'b1;

    // Configuration reset values
    localparam logic [LVL_W-1:0] WARN_LEVEL_RST = 5'd12;
    localparam logic [LVL_W-1:0] CRIT_LEVEL_RST = 5'd15;

    // Per-cycle control broadcast along the cell row
    typedef struct packed {
        logic push;   // store frame into the first free cell
        logic pop;    // every cell takes its upper neighbor's frame
    } cell_ctrl_t;

endpackage : fmw_pkg
`default_nettype wire

### src/fmw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmw_if
// Valid/ready channels for FIFO commands and per-command status words.
// ----------------------------------------------------------------------------
interface fmw_cmd_if;
    import fmw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [FRAME_BUS_W-1:0] frame_in;

    modport source (output valid, action, frame_in, input ready);
    modport sink   (input valid, action, frame_in, output ready);
endinterface : fmw_cmd_if

interface fmw_rsp_if;
    import fmw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [FRAME_BUS_W-1:0] frame_out;
    logic [OCC_W-1:0]       occupancy;
    logic                   warning_flag;
    logic                   critical_flag;
    logic                   overflow_flag;
    logic [TOTAL_W-1:0]     received_count;
    logic [TOTAL_W-1:0]     processed_count;
    logic [TOTAL_W-1:0]     dropped_count;
    logic [OCC_W-1:0]       peak_occupancy;

    modport source (
        output valid, ok, frame_out, occupancy, warning_flag, critical_flag,
               overflow_flag, received_count, processed_count, dropped_count,
               peak_occupancy,
        input  ready
    );
    modport sink (
        input  valid, ok, frame_out, occupancy, warning_flag, critical_flag,
               overflow_flag, received_count, processed_count, dropped_count,
               peak_occupancy,
        output ready
    );
endinterface : fmw_rsp_if
`default_nettype wire

### src/fmw_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmw_cell
// One storage cell of the frame row: loads a new frame when it is the first
// free slot, and takes its upper neighbor's frame when the row shifts.
// ----------------------------------------------------------------------------
module fmw_cell #(
    parameter int FRAME_WIDTH = fmw_pkg::DEF_FRAME_WIDTH,
    parameter int CNT_W       = 5,
    parameter int IDX         = 0
) (
    input  wire                     clk,
    input  wire fmw_pkg::cell_ctrl_t ctrl,
    input  wire [CNT_W-1:0]         count,
    input  wire [FRAME_WIDTH-1:0]   frame_in,
    input  wire [FRAME_WIDTH-1:0]   upper,
    output logic [FRAME_WIDTH-1:0]  data
);
    import fmw_pkg::*;

    logic [FRAME_WIDTH-1:0] data_reg;
    logic [FRAME_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.pop)
        begin
            data_next = upper;
        end
        else if (ctrl.push && (count == CNT_W'(IDX)))
        begin
            data_next = frame_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule : fmw_cell
`default_nettype wire

### src/frame_fifo_with_watermarks.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_fifo_with_watermarks
// Frame FIFO built as a row of shifting cells, with occupancy watermark
// flags, sticky overflow, wrapping totals and a high-water mark.
// ----------------------------------------------------------------------------
// Each cmd word is a push (action 0) or a pop (action 1) and yields exactly
// one rsp word carrying the status after that command. One command is taken
// per clock unless rsp stalls: the rsp word sits in an output register, and
// cmd.ready stays high while it is empty or being drained, so throughput is
// one word per cycle. Storage is a row of DEPTH cells: cell 0 always holds the
// oldest frame; a push loads the first free cell (the one whose index equals
// the fill count), a pop shifts every cell down by one. Only the low
// FRAME_WIDTH bits of a frame are kept; frame_out is zero unless a pop
// returned a frame. The user writes warning/critical levels via the cfg port
// only while idle, unenforced by the block; crit implies warn by construction.
// ----------------------------------------------------------------------------
module frame_fifo_with_watermarks #(
    parameter int DEPTH       = fmw_pkg::DEF_DEPTH,
    parameter int FRAME_WIDTH = fmw_pkg::DEF_FRAME_WIDTH
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [fmw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [fmw_pkg::LVL_W-1:0]         cfg_wdata,
    fmw_cmd_if.sink                          cmd,
    fmw_rsp_if.source                        rsp
);
    import fmw_pkg::*;

    // Fill count must hold DEPTH itself; compares run at least as wide as
    // the level registers.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > LVL_W) ? CNT_W : LVL_W;

    // ---------------- configuration ----------------
    logic [LVL_W-1:0] warn_lvl_reg;
    logic [LVL_W-1:0] crit_lvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_lvl_reg <= WARN_LEVEL_RST;
            crit_lvl_reg <= CRIT_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WARN_LEVEL: warn_lvl_reg <= cfg_wdata;
                REG_CRIT_LEVEL: crit_lvl_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic cmd_acc;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign cmd_acc   = cmd.valid && cmd.ready;

    // ---------------- control state ----------------
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic               warn_reg,      warn_next;
    logic               crit_reg,      crit_next;
    logic               ovf_reg,       ovf_next;
    logic [TOTAL_W-1:0] rcvd_reg,      rcvd_next;
    logic [TOTAL_W-1:0] proc_reg,      proc_next;
    logic [TOTAL_W-1:0] drop_reg,      drop_next;
    logic [CNT_W-1:0]   hw_reg,        hw_next;

    logic       is_push;
    logic       full;
    logic       empty;
    logic       push_ok;
    logic       pop_ok;
    logic       push_drop;
    logic [CMP_W-1:0] cnt_wide;
    logic [CMP_W-1:0] hw_wide;
    cell_ctrl_t ctrl;

    assign is_push   = (cmd.action == ACT_PUSH);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign push_ok   = cmd_acc && is_push && !full;
    assign push_drop = cmd_acc && is_push && full;
    assign pop_ok    = cmd_acc && (cmd.action == ACT_POP) && !empty;

    assign ctrl.push = push_ok;
    assign ctrl.pop  = pop_ok;

    always_comb
    begin
        count_next = count_reg;
        warn_next  = warn_reg;
        crit_next  = crit_reg;
        ovf_next   = ovf_reg;
        rcvd_next  = rcvd_reg;
        proc_next  = proc_reg;
        drop_next  = drop_reg;
        hw_next    = hw_reg;

        if (push_ok)
        begin
            count_next = count_reg + 1'b1;
            rcvd_next  = rcvd_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            count_next = count_reg - 1'b1;
            proc_next  = proc_reg + 1'b1;
        end

        if (push_drop)
        begin
            drop_next = drop_reg + 1'b1;
            ovf_next  = 1'b1;
        end

        cnt_wide = CMP_W'(count_next);

        if (push_ok)
        begin
            if (count_next > hw_reg)
            begin
                hw_next = count_next;
            end
            if (cnt_wide >= CMP_W'(warn_lvl_reg))
            begin
                warn_next = 1'b1;
                if (cnt_wide >= CMP_W'(crit_lvl_reg))
                begin
                    crit_next = 1'b1;
                end
            end
            else
            begin
                warn_next = 1'b0;
                crit_next = 1'b0;
            end
        end
        else if (pop_ok && (cnt_wide < CMP_W'(warn_lvl_reg)))
        begin
            warn_next = 1'b0;
            crit_next = 1'b0;
        end

        hw_wide = CMP_W'(hw_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            warn_reg  <= 1'b0;
            crit_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            rcvd_reg  <= '0;
            proc_reg  <= '0;
            drop_reg  <= '0;
            hw_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            warn_reg  <= warn_next;
            crit_reg  <= crit_next;
            ovf_reg   <= ovf_next;
            rcvd_reg  <= rcvd_next;
            proc_reg  <= proc_next;
            drop_reg  <= drop_next;
            hw_reg    <= hw_next;
        end
    end

    // ---------------- cell row ----------------
    logic [FRAME_WIDTH-1:0] frame_keep;
    logic [FRAME_WIDTH-1:0] cell_data [DEPTH];

    assign frame_keep = cmd.frame_in[FRAME_WIDTH-1:0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [FRAME_WIDTH-1:0] upper;

        if (i == DEPTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = cell_data[i+1];
        end

        fmw_cell #(
            .FRAME_WIDTH (FRAME_WIDTH),
            .CNT_W       (CNT_W),
            .IDX         (i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .count    (count_reg),
            .frame_in (frame_keep),
            .upper    (upper),
            .data     (cell_data[i])
        );
    end

    // ---------------- rsp register ----------------
    // Payload has no reset; valid qualifies it.
    logic                   ok_reg;
    logic [FRAME_BUS_W-1:0] fout_reg;
    logic [FRAME_BUS_W-1:0] fout_next;
    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       peak_reg;
    logic                   rsp_warn_reg;
    logic                   rsp_crit_reg;
    logic                   rsp_ovf_reg;
    logic [TOTAL_W-1:0]     rsp_rcvd_reg;
    logic [TOTAL_W-1:0]     rsp_proc_reg;
    logic [TOTAL_W-1:0]     rsp_drop_reg;

    // Oldest frame always sits in cell 0
    assign fout_next = pop_ok ? FRAME_BUS_W'(cell_data[0]) : '0;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd_acc)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            ok_reg       <= push_ok || pop_ok;
            fout_reg     <= fout_next;
            occ_reg      <= cnt_wide[OCC_W-1:0];
            peak_reg     <= hw_wide[OCC_W-1:0];
            rsp_warn_reg <= warn_next;
            rsp_crit_reg <= crit_next;
            rsp_ovf_reg  <= ovf_next;
            rsp_rcvd_reg <= rcvd_next;
            rsp_proc_reg <= proc_next;
            rsp_drop_reg <= drop_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.ok              = ok_reg;
    assign rsp.frame_out       = fout_reg;
    assign rsp.occupancy       = occ_reg;
    assign rsp.warning_flag    = rsp_warn_reg;
    assign rsp.critical_flag   = rsp_crit_reg;
    assign rsp.overflow_flag   = rsp_ovf_reg;
    assign rsp.received_count  = rsp_rcvd_reg;
    assign rsp.processed_count = rsp_proc_reg;
    assign rsp.dropped_count   = rsp_drop_reg;
    assign rsp.peak_occupancy  = peak_reg;

endmodule : frame_fifo_with_watermarks
`default_nettype wire

### src/fmw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmw_checker
// Port-level checks for the frame FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module fmw_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              rsp_valid,
    input wire                              rsp_ready,
    input wire                              ok,
    input wire [fmw_pkg::FRAME_BUS_W-1:0]   frame_out,
    input wire [fmw_pkg::OCC_W-1:0]         occupancy,
    input wire                              warning_flag,
    input wire                              critical_flag
);
    import fmw_pkg::*;

    // Stalled status word stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(occupancy) && $stable(ok))
        else $error("rsp word changed while stalled");

    // Critical is only ever set together with warning
    a_crit_warn: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!critical_flag || warning_flag))
        else $error("critical flag without warning flag");

    // Failed command returns no frame data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> (frame_out == '0))
        else $error("frame_out nonzero on failed command");

    // A pop that empties the FIFO never leaves critical showing on its own
    a_empty_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ok && (occupancy == '0) |-> (warning_flag == critical_flag) ||
            warning_flag)
        else $error("inconsistent flags on empty FIFO");

endmodule : fmw_checker

bind frame_fifo_with_watermarks fmw_checker u_fmw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .ok            (rsp.ok),
    .frame_out     (rsp.frame_out),
    .occupancy     (rsp.occupancy),
    .warning_flag  (rsp.warning_flag),
    .critical_flag (rsp.critical_flag)
);
`default_nettype wire
